@@ rtl/spa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared field widths, request codes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spa_pkg;

	// Field widths of the input and result beats.
	localparam int COEF_W = 16;
	localparam int EXP_W  = 16;
	localparam int SUM_W  = 17;
	localparam int REQ_W  = 2;

	// Request codes carried on req_type.
	localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

	// One stored term: exponent in the upper half, coefficient in the lower.
	typedef struct packed {
		logic [EXP_W-1:0]         exp;
		logic signed [COEF_W-1:0] coef;
	} term_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic step;
		logic clear;
	} spa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic last;
	} spa_sts_t;

endpackage

@@ rtl/spa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder controller
// Decodes input requests into load commands and sequences the merge, one
// result beat per step while the output register can take it.
// ----------------------------------------------------------------------------
module spa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [spa_pkg::REQ_W-1:0]  req_type,
	input  spa_pkg::spa_sts_t          sts,
	output spa_pkg::spa_cmd_t          cmd
);
	import spa_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	state_t state_q;
	logic   in_take;

	// Input beats are taken only while no merge is running.
	assign in_stall = (state_q == ST_MERGE);
	assign in_take  = in_valid && (state_q == ST_IDLE);

	// Command decode.
	always_comb begin
		cmd.load_a = in_take && (req_type == REQ_LOAD_A);
		cmd.load_b = in_take && (req_type == REQ_LOAD_B);
		cmd.step   = (state_q == ST_MERGE) && sts.slot_free;
		cmd.clear  = cmd.step && sts.last;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && (req_type == REQ_START)) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (cmd.clear) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/spa_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder datapath
// Holds the two term stores with their fill counts, the merge read pointers,
// the head compare and add, and the output register.
// ----------------------------------------------------------------------------
module spa_dpath #(
	parameter int MAX_TERMS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spa_pkg::spa_cmd_t                 cmd,
	output spa_pkg::spa_sts_t                 sts,
	input  logic signed [spa_pkg::COEF_W-1:0] coefficient,
	input  logic [spa_pkg::EXP_W-1:0]         exponent,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [spa_pkg::SUM_W-1:0]  sum_coefficient,
	output logic [spa_pkg::EXP_W-1:0]         sum_exponent,
	output logic                              is_empty,
	output logic                              terms_dropped,
	output logic                              last_term
);
	import spa_pkg::*;

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	term_t mem_a [MAX_TERMS];
	term_t mem_b [MAX_TERMS];
	term_t rd_a_q, rd_b_q;
	term_t term_in;

	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic [CNT_W-1:0] ia_q, ib_q, ia_d, ib_d;
	logic [IDX_W-1:0] addr_a, addr_b;
	logic             overflow_q;
	logic             full_a, full_b;
	logic             a_live, b_live, both_empty;
	logic             adv_a, adv_b;
	logic signed [SUM_W-1:0] coef_a_ext, coef_b_ext, res_coef;
	logic [EXP_W-1:0] res_exp;
	logic             out_valid_q;

	assign term_in = '{exp: exponent, coef: coefficient};
	assign full_a  = (count_a_q >= CNT_MAX);
	assign full_b  = (count_b_q >= CNT_MAX);

	// Fill counts and the sticky drop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.clear) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (cmd.load_a) begin
				if (full_a) begin
					overflow_q <= 1'b1;
				end else begin
					count_a_q <= count_a_q + CNT_ONE;
				end
			end
			if (cmd.load_b) begin
				if (full_b) begin
					overflow_q <= 1'b1;
				end else begin
					count_b_q <= count_b_q + CNT_ONE;
				end
			end
		end
	end

	// Next read pointers; the stores are read at the pointer they move to.
	always_comb begin
		if (cmd.clear) begin
			ia_d = '0;
			ib_d = '0;
		end else begin
			ia_d = (cmd.step && adv_a) ? ia_q + CNT_ONE : ia_q;
			ib_d = (cmd.step && adv_b) ? ib_q + CNT_ONE : ib_q;
		end
		addr_a = (ia_d < CNT_MAX) ? ia_d[IDX_W-1:0] : '0;
		addr_b = (ib_d < CNT_MAX) ? ib_d[IDX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ia_q <= '0;
			ib_q <= '0;
		end else begin
			ia_q <= ia_d;
			ib_q <= ib_d;
		end
	end

	// Term stores: one write port for loads, one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.load_a && !full_a) begin
			mem_a[count_a_q[IDX_W-1:0]] <= term_in;
		end
		rd_a_q <= mem_a[addr_a];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_b && !full_b) begin
			mem_b[count_b_q[IDX_W-1:0]] <= term_in;
		end
		rd_b_q <= mem_b[addr_b];
	end

	// Head compare: pick the larger exponent, add on a tie.
	assign a_live     = (ia_q < count_a_q);
	assign b_live     = (ib_q < count_b_q);
	assign both_empty = (count_a_q == '0) && (count_b_q == '0);
	assign coef_a_ext = SUM_W'(rd_a_q.coef);
	assign coef_b_ext = SUM_W'(rd_b_q.coef);

	always_comb begin
		priority if (a_live && b_live) begin
			if (rd_a_q.exp > rd_b_q.exp) begin
				adv_a    = 1'b1;
				adv_b    = 1'b0;
				res_coef = coef_a_ext;
				res_exp  = rd_a_q.exp;
			end else if (rd_a_q.exp < rd_b_q.exp) begin
				adv_a    = 1'b0;
				adv_b    = 1'b1;
				res_coef = coef_b_ext;
				res_exp  = rd_b_q.exp;
			end else begin
				adv_a    = 1'b1;
				adv_b    = 1'b1;
				res_coef = coef_a_ext + coef_b_ext;
				res_exp  = rd_a_q.exp;
			end
		end else if (a_live) begin
			adv_a    = 1'b1;
			adv_b    = 1'b0;
			res_coef = coef_a_ext;
			res_exp  = rd_a_q.exp;
		end else if (b_live) begin
			adv_a    = 1'b0;
			adv_b    = 1'b1;
			res_coef = coef_b_ext;
			res_exp  = rd_b_q.exp;
		end else begin
			adv_a    = 1'b0;
			adv_b    = 1'b0;
			res_coef = '0;
			res_exp  = '0;
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.slot_free = !out_valid_q || !out_stall;
		sts.last      = both_empty ||
			((ia_q + CNT_W'(adv_a) >= count_a_q) && (ib_q + CNT_W'(adv_b) >= count_b_q));
	end

	// Output register: loaded on each step, emptied when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			sum_coefficient <= res_coef;
			sum_exponent    <= res_exp;
			is_empty        <= both_empty;
			terms_dropped   <= overflow_q;
			last_term       <= sts.last;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	// Fill counts never pass the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= CNT_MAX) && (count_b_q <= CNT_MAX))
		else $error("term store count exceeds depth");

	// Read pointers never run past the fill counts during a merge.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (ia_q <= count_a_q) && (ib_q <= count_b_q))
		else $error("merge pointer past fill count");

	// A non-empty step always has a head to emit.
	a_step_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !both_empty) |-> (a_live || b_live))
		else $error("merge step with both stores exhausted");

	// The end of a merge empties both stores and the drop flag.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_a_q == '0) && (count_b_q == '0) && !overflow_q
			&& (ia_q == '0) && (ib_q == '0))
		else $error("stores not cleared after merge");
`endif

endmodule

@@ rtl/sparse_polynomial_add.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// Loads two term lists and merges them into their sum, highest exponent first.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per beat: req_type selects a load
//   into store A, a load into store B, or a start of the merge. Code 3 is
//   taken and ignored. Loads are taken one per cycle; a load into a full store
//   is dropped and sets the drop flag reported on every result beat. A start
//   is followed by the merge: the first result beat shows on out_valid once a
//   merge step loads the output register, then one beat per cycle while the
//   receiver does not stall. A merge of na and nb terms gives between
//   max(na, nb) and na + nb beats (one beat marked is_empty if both stores are
//   empty); the merge walks the two store read ports, taking the larger head
//   or both on a tie. in_stall stays high for the whole merge and drops in the
//   cycle after the beat marked last_term is produced; the stores and the drop
//   flag are then cleared. A stall on the output holds the beat in the output
//   register and pauses the merge. Reset empties both stores, clears the drop
//   flag and drops out_valid; the store contents themselves are not cleared.
// ----------------------------------------------------------------------------
module sparse_polynomial_add #(
	parameter int MAX_TERMS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [spa_pkg::REQ_W-1:0]         req_type,
	input  logic signed [spa_pkg::COEF_W-1:0] coefficient,
	input  logic [spa_pkg::EXP_W-1:0]         exponent,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [spa_pkg::SUM_W-1:0]  sum_coefficient,
	output logic [spa_pkg::EXP_W-1:0]         sum_exponent,
	output logic                              is_empty,
	output logic                              terms_dropped,
	output logic                              last_term
);
	import spa_pkg::*;

	spa_cmd_t cmd;
	spa_sts_t sts;

	// Request decode and merge sequencing.
	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Term stores, merge compare and output register.
	spa_dpath #(
		.MAX_TERMS (MAX_TERMS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.coefficient     (coefficient),
		.exponent        (exponent),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sum_coefficient (sum_coefficient),
		.sum_exponent    (sum_exponent),
		.is_empty        (is_empty),
		.terms_dropped   (terms_dropped),
		.last_term       (last_term)
	);

endmodule

@@ tb/sparse_polynomial_add_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder testbench
// Loads term lists into stores A and B, starts merges and checks every result
// beat field by field. Each beat is checked against a behavioral model of the
// two stores. A short directed table runs first. Random term sets follow: most
// are ordered, some are unordered, and some overfill a store. Both sides of
// the block idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_tb;
	import spa_pkg::*;

	localparam int MAX_TERMS = 32;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRILL_ROWS = 26;
	localparam int LIST_DEPTH = 40;

	// One merged term as it leaves the block.
	typedef struct packed {
		logic signed [SUM_W-1:0] coef;
		logic [EXP_W-1:0]        expo;
		logic                    empty;
		logic                    dropped;
		logic                    last;
	} sum_term_t;

	// One row of the directed table. Rows with typed set carry their own result.
	typedef struct {
		logic [REQ_W-1:0]         req;
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0]         expo;
		bit                       typed;
		sum_term_t                want;
	} drill_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [REQ_W-1:0]         req_type;
	logic signed [COEF_W-1:0] coefficient;
	logic [EXP_W-1:0]         exponent;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [SUM_W-1:0]  sum_coefficient;
	logic [EXP_W-1:0]         sum_exponent;
	logic                     is_empty;
	logic                     terms_dropped;
	logic                     last_term;

	// Model of the two term stores and the drop flag.
	term_t model_a [MAX_TERMS];
	term_t model_b [MAX_TERMS];
	int    model_cnt_a = 0;
	int    model_cnt_b = 0;
	logic  model_dropped = 1'b0;

	// Merged terms still owed by the block, oldest first.
	sum_term_t expected_terms [$];

	int errors = 0;
	int beats_checked = 0;
	int merges = 0;
	int drop_events = 0;
	int ignored_items = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	drill_row_t drills [DRILL_ROWS] = '{
		'{REQ_START,  16'sd0,     16'd0,     1'b1, '{17'sd0, 16'd0, 1'b1, 1'b0, 1'b1}},
		'{REQ_UNUSED, -16'sd1,    16'hffff,  1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b1, '{17'sd0, 16'd0, 1'b1, 1'b0, 1'b1}},
		'{REQ_LOAD_A, 16'sh8000,  16'hffff,  1'b0, '0},
		'{REQ_LOAD_B, 16'sh8000,  16'hffff,  1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b1,
			'{17'sh10000, 16'hffff, 1'b0, 1'b0, 1'b1}},
		'{REQ_LOAD_A, 16'sd32767, 16'hffff,  1'b0, '0},
		'{REQ_LOAD_B, 16'sd32767, 16'hffff,  1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b1,
			'{17'sd65534, 16'hffff, 1'b0, 1'b0, 1'b1}},
		'{REQ_LOAD_A, 16'sd5,     16'd0,     1'b0, '0},
		'{REQ_LOAD_B, -16'sd5,    16'd0,     1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b1, '{17'sd0, 16'd0, 1'b0, 1'b0, 1'b1}},
		'{REQ_LOAD_A, 16'sd3,     16'd10,    1'b0, '0},
		'{REQ_LOAD_A, 16'sd2,     16'd4,     1'b0, '0},
		'{REQ_LOAD_B, 16'sd7,     16'd8,     1'b0, '0},
		'{REQ_LOAD_B, 16'sd1,     16'd4,     1'b0, '0},
		'{REQ_LOAD_B, -16'sd9,    16'd0,     1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b0, '0},
		'{REQ_LOAD_A, 16'sd1,     16'd2,     1'b0, '0},
		'{REQ_LOAD_A, 16'sd4,     16'd9,     1'b0, '0},
		'{REQ_LOAD_B, 16'sd6,     16'd5,     1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b0, '0},
		'{REQ_LOAD_B, 16'sd11,    16'd300,   1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b0, '0},
		'{REQ_LOAD_A, -16'sd700,  16'd1,     1'b0, '0},
		'{REQ_START,  16'sd0,     16'd0,     1'b0, '0}
	};

	sparse_polynomial_add #(
		.MAX_TERMS(MAX_TERMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.coefficient(coefficient),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_coefficient(sum_coefficient),
		.sum_exponent(sum_exponent),
		.is_empty(is_empty),
		.terms_dropped(terms_dropped),
		.last_term(last_term)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: no progress after %0d cycles", $time, cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Apply one accepted request to the store model and queue the terms it owes.
	function automatic void fold_request(input logic [REQ_W-1:0] req,
			input logic signed [COEF_W-1:0] c, input logic [EXP_W-1:0] e);
		term_t t;
		sum_term_t r;
		int ia;
		int ib;
		t.exp = e;
		t.coef = c;
		ia = 0;
		ib = 0;
		case (req)
			REQ_LOAD_A: begin
				if (model_cnt_a < MAX_TERMS) begin
					model_a[model_cnt_a] = t;
					model_cnt_a++;
				end else begin
					model_dropped = 1'b1;
					drop_events++;
				end
			end
			REQ_LOAD_B: begin
				if (model_cnt_b < MAX_TERMS) begin
					model_b[model_cnt_b] = t;
					model_cnt_b++;
				end else begin
					model_dropped = 1'b1;
					drop_events++;
				end
			end
			REQ_START: begin
				merges++;
				if (model_cnt_a == 0 && model_cnt_b == 0) begin
					r = '{17'sd0, 16'd0, 1'b1, model_dropped, 1'b1};
					expected_terms.push_back(r);
				end
				// Walk both heads: larger exponent first, equal exponents summed.
				while (ia < model_cnt_a || ib < model_cnt_b) begin
					r.empty = 1'b0;
					r.dropped = model_dropped;
					if (ia < model_cnt_a && ib < model_cnt_b &&
							model_a[ia].exp == model_b[ib].exp) begin
						r.coef = $signed(model_a[ia].coef) + $signed(model_b[ib].coef);
						r.expo = model_a[ia].exp;
						ia++;
						ib++;
					end else if (ia < model_cnt_a &&
							(ib >= model_cnt_b || model_a[ia].exp > model_b[ib].exp)) begin
						r.coef = $signed(model_a[ia].coef);
						r.expo = model_a[ia].exp;
						ia++;
					end else begin
						r.coef = $signed(model_b[ib].coef);
						r.expo = model_b[ib].exp;
						ib++;
					end
					r.last = (ia >= model_cnt_a && ib >= model_cnt_b);
					expected_terms.push_back(r);
				end
				model_cnt_a = 0;
				model_cnt_b = 0;
				model_dropped = 1'b0;
			end
			default: ignored_items++;
		endcase
	endfunction

	function automatic void check_field(input string name,
			input logic signed [31:0] want, input logic signed [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	// Compare every result beat with the oldest owed term.
	always @(posedge clk) begin
		sum_term_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_terms.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none got coef %0d exp %0d",
					$time, sum_coefficient, sum_exponent);
			end else begin
				want = expected_terms.pop_front();
				beats_checked++;
				check_field("sum_coefficient", 32'(want.coef), 32'(sum_coefficient));
				check_field("sum_exponent", 32'(want.expo), 32'(sum_exponent));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
				check_field("terms_dropped", 32'(want.dropped), 32'(terms_dropped));
				check_field("last_term", 32'(want.last), 32'(last_term));
			end
		end
	end

	// Receiver: random stalls, none while calm, and one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 30);
			end
		end
	end

	// Offer one request beat, wait until it is taken, then update the model.
	task automatic deliver(input logic [REQ_W-1:0] req,
			input logic signed [COEF_W-1:0] c, input logic [EXP_W-1:0] e);
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		coefficient <= c;
		exponent <= e;
		do @(posedge clk); while (in_stall);
		fold_request(req, c, e);
	endtask

	// Sender idles now and then, never while calm.
	task automatic idle_gap();
		int n;
		if (!calm && $urandom_range(0, 99) < 20) begin
			n = $urandom_range(1, 3);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	initial begin
		logic [EXP_W-1:0]         exps_a [LIST_DEPTH];
		logic [EXP_W-1:0]         exps_b [LIST_DEPTH];
		logic signed [COEF_W-1:0] coefs_a [LIST_DEPTH];
		logic signed [COEF_W-1:0] coefs_b [LIST_DEPTH];
		int na;
		int nb;
		int ia;
		int ib;
		int cur_a;
		int cur_b;
		int items;
		int set_idx;
		bit ordered;

		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD_A;
		coefficient = '0;
		exponent = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: typed rows override the model's result.
		foreach (drills[i]) begin
			deliver(drills[i].req, drills[i].coef, drills[i].expo);
			if (drills[i].typed)
				expected_terms[expected_terms.size() - 1] = drills[i].want;
			idle_gap();
		end

		// Random term sets, each closed by a start.
		items = 0;
		set_idx = 0;
		while (items < RANDOM_ITEMS) begin
			calm = (set_idx >= 12 && set_idx < 20);
			ordered = ($urandom_range(0, 99) < 80);
			if (set_idx == 0) begin
				// Overfill both stores.
				na = 35;
				nb = 33;
			end else if (set_idx == 2) begin
				// Receiver holds off while this merge runs and the next set queues up.
				na = 8;
				nb = 8;
				hold_req = 1'b1;
			end else if ($urandom_range(0, 99) < 4) begin
				na = $urandom_range(28, 34);
				nb = $urandom_range(0, 34);
			end else if ($urandom_range(0, 99) < 5) begin
				na = 0;
				nb = 0;
			end else begin
				na = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			end

			// Build the lists: ordered lists walk down from a top exponent that A and B mostly share.
			cur_a = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
			cur_b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : cur_a;
			for (int k = 0; k < LIST_DEPTH; k++) begin
				if (ordered) begin
					exps_a[k] = cur_a[EXP_W-1:0];
					exps_b[k] = cur_b[EXP_W-1:0];
					cur_a = cur_a - $urandom_range(1, 3);
					cur_b = cur_b - $urandom_range(1, 3);
					if (cur_a < 0) cur_a = 0;
					if (cur_b < 0) cur_b = 0;
				end else begin
					exps_a[k] = EXP_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
					exps_b[k] = EXP_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
				end
				case ($urandom_range(0, 9))
					0: coefs_a[k] = 16'sh8000;
					1: coefs_a[k] = 16'sd32767;
					default: coefs_a[k] = COEF_W'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: coefs_b[k] = 16'sh8000;
					1: coefs_b[k] = 16'sd32767;
					2: coefs_b[k] = -coefs_a[k];
					default: coefs_b[k] = COEF_W'($urandom);
				endcase
			end

			// Interleave the loads, with an unused request code now and then.
			ia = 0;
			ib = 0;
			while (ia < na || ib < nb) begin
				if ($urandom_range(0, 99) < 5) begin
					deliver(REQ_UNUSED, COEF_W'($urandom), EXP_W'($urandom));
					idle_gap();
				end
				if (ia < na && (ib >= nb || $urandom_range(0, 1) == 1)) begin
					deliver(REQ_LOAD_A, coefs_a[ia], exps_a[ia]);
					ia++;
				end else begin
					deliver(REQ_LOAD_B, coefs_b[ib], exps_b[ib]);
					ib++;
				end
				items++;
				idle_gap();
			end
			deliver(REQ_START, COEF_W'($urandom), EXP_W'($urandom));
			items++;
			idle_gap();
			set_idx++;
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_terms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d merges and checked %0d result beats against the store model.",
			merges, beats_checked);
		$display("%0d loads hit a full store and %0d beats carried the unused request code.",
			drop_events, ignored_items);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
